FILE: sv/credit_return_ingress_defines.svh
// ----------------------------------------------------------------------------
// Credit return ingress assertion macros
// Concurrent check wrappers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef CREDIT_RETURN_INGRESS_DEFINES_SVH
`define CREDIT_RETURN_INGRESS_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define CRI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("credit_return_ingress check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define CRI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("credit_return_ingress check failed");
`else
`define CRI_ASSERT_NOW(label, ante, cons)
`define CRI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/cri_pkg.sv
// ----------------------------------------------------------------------------
// Credit return ingress package
// Shared widths, constants, codes and the update result struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cri_pkg;

  // Shared regional buffer size in entries (power of two).
  localparam int FIFO_SIZE    = 1024;
  localparam int CHANNELS_DEF = 16;

  localparam int CW        = 11;   // per-channel / regional count width
  localparam int CH_W      = 4;    // channel field width
  localparam int SID_W     = 8;    // service id width
  localparam int CC_W      = 5;    // channel_count register width
  localparam int MB_W      = 11;   // min_channel_buffer register width
  localparam int RCV_W     = 32;   // received total width
  localparam int WORD_W    = 19;   // return word width
  localparam int PW        = CC_W + MB_W;      // threshold product width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;

  localparam logic [CW-1:0] CNT_MAX   = CW'(2 * FIFO_SIZE - 1);
  localparam logic [CW-1:0] HALF_FIFO = CW'(FIFO_SIZE / 2);
  localparam int            SID_SHIFT = $clog2(2 * FIFO_SIZE);

  // Reset values of the configuration registers.
  localparam logic [CC_W-1:0] CC_RST  = CC_W'(16);
  localparam logic [MB_W-1:0] MB_RST  = MB_W'(16);
  localparam logic [SID_W-1:0] FID_RST = '0;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_CHECK   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_MIN_BUFFER    = 2'd1,
    CFG_FLOW_ID       = 2'd2
  } cfg_idx_t;

  // Outcome of one read-modify-write step on a channel entry.
  typedef struct packed {
    logic          fire;     // credits handed back
    logic          ch_wr;    // channel entry is rewritten
    logic [CW-1:0] ch_new;   // new channel credits
    logic [CW-1:0] reg_new;  // new regional total
    logic [CW-1:0] give;     // credits returned
  } upd_t;

endpackage

FILE: sv/credit_return_ingress.sv
// ----------------------------------------------------------------------------
// Credit return ingress
// Receive side of credit flow control for channels sharing one buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per event. op acquire adds
//   credit_amount to the channel, the regional total and the received total;
//   op check hands the channel's credits back when the return rule holds.
//   Output channel (out_valid/out_ready): exactly one result word per input
//   word, in order, carrying the return message fields and both totals.
//   Config port (cfg_we/cfg_index/cfg_wdata): single-cycle register writes,
//   issued only while the block is idle; the threshold updates the cycle after.
//   Flow: an accepted word is registered in the update stage, then in the
//   output register. Throughput: one word per cycle unless the output is
//   held, set by the single channel-credit RAM reading at accept and writing
//   as the word advances; back-to-back hits on one channel use forwarding.
//   Reset: rst_n low clears all credit counts through per-entry valid bits,
//   so no clearing pass is needed; the block is ready right after reset.
//   Stall: a held output word keeps one word in the update stage; further
//   input waits (in_ready low) until the output register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "credit_return_ingress_defines.svh"

module credit_return_ingress #(
  parameter int CHANNELS = cri_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [cri_pkg::CH_W-1:0]      in_channel,
  input  logic [cri_pkg::SID_W-1:0]     in_service_id,
  input  logic [cri_pkg::CW-1:0]        in_credit_amount,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_returned,
  output logic [cri_pkg::SID_W-1:0]     out_message_service,
  output logic [cri_pkg::WORD_W-1:0]    out_return_word,
  output logic [cri_pkg::CW-1:0]        out_returned_count,
  output logic [cri_pkg::CW-1:0]        out_regional_level,
  output logic [cri_pkg::RCV_W-1:0]     out_received_total,
  // configuration
  input  logic                          cfg_we,
  input  logic [cri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cri_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [cri_pkg::CC_W-1:0]  chan_cnt_r;
  logic [cri_pkg::MB_W-1:0]  min_buf_r;
  logic [cri_pkg::SID_W-1:0] flow_id_r;
  logic [cri_pkg::CW-1:0]    thr;

  // Accept / update stage.
  logic                       accept;
  logic                       adv;
  logic [AW-1:0]              rd_idx;
  logic                       in_rng;
  logic                       s1_v_r;
  logic                       s1_op_r;
  logic                       s1_inr_r;
  logic [AW-1:0]              s1_idx_r;
  logic [cri_pkg::SID_W-1:0]  s1_sid_r;
  logic [cri_pkg::CW-1:0]     s1_amt_r;
  logic                       s1_vld_r;
  logic [cri_pkg::CW-1:0]     rd_data;
  logic [cri_pkg::CW-1:0]     cur_credits;

  // Forwarding of a write that lands at the same edge as a read.
  logic                       fwd_hit_r;
  logic [cri_pkg::CW-1:0]     fwd_data_r;

  // Per-entry valid bits stand in for a zero-cleared RAM.
  logic [CHANNELS-1:0]        chan_vld_r;

  // Totals.
  logic [cri_pkg::CW-1:0]     regional_r;
  logic [cri_pkg::RCV_W-1:0]  received_r;
  logic [cri_pkg::RCV_W-1:0]  received_nxt;

  cri_pkg::upd_t              upd;
  logic                       ram_we;

  // Output register.
  logic                       out_valid_r;
  logic                       out_returned_r;
  logic [cri_pkg::SID_W-1:0]  out_msg_r;
  logic [cri_pkg::WORD_W-1:0] out_word_r;
  logic [cri_pkg::CW-1:0]     out_cnt_r;
  logic [cri_pkg::CW-1:0]     out_reg_r;
  logic [cri_pkg::RCV_W-1:0]  out_rcv_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= cri_pkg::CC_RST;
      min_buf_r  <= cri_pkg::MB_RST;
      flow_id_r  <= cri_pkg::FID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cri_pkg::CFG_CHANNEL_COUNT: chan_cnt_r <= cri_pkg::CC_W'(cfg_wdata);
        cri_pkg::CFG_MIN_BUFFER:    min_buf_r  <= cri_pkg::MB_W'(cfg_wdata);
        cri_pkg::CFG_FLOW_ID:       flow_id_r  <= cri_pkg::SID_W'(cfg_wdata);
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  cri_thresh u_thresh (
    .clk           (clk),
    .channel_count (chan_cnt_r),
    .min_buffer    (min_buf_r),
    .thr           (thr)
  );

  // --------------------------------------------------------------- control
  // Advance the update stage when the output register is free or draining.
  assign adv      = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || adv;
  assign accept   = in_valid && in_ready;

  assign rd_idx = AW'(in_channel);
  assign in_rng = (32'(in_channel) < CHANNELS);

  // ------------------------------------------------------- channel credits
  assign ram_we = adv && upd.ch_wr;

  cri_ram #(
    .WIDTH (cri_pkg::CW),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx_r),
    .wdata (upd.ch_new),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // Forwarded value wins, then the RAM word if the entry was ever written.
  assign cur_credits = fwd_hit_r ? fwd_data_r : (s1_vld_r ? rd_data : '0);

  cri_update u_update (
    .op       (s1_op_r),
    .in_range (s1_inr_r),
    .credits  (cur_credits),
    .regional (regional_r),
    .amount   (s1_amt_r),
    .thr      (thr),
    .upd      (upd)
  );

  assign received_nxt = (s1_inr_r && (s1_op_r == cri_pkg::OP_ACQUIRE))
                        ? received_r + cri_pkg::RCV_W'(s1_amt_r) : received_r;

  // Stage valid, forwarding and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      fwd_hit_r  <= 1'b0;
      chan_vld_r <= '0;
      regional_r <= '0;
      received_r <= '0;
    end else begin
      if (accept) begin
        s1_v_r    <= 1'b1;
        fwd_hit_r <= ram_we && (s1_idx_r == rd_idx);
      end else if (adv) begin
        s1_v_r    <= 1'b0;
        fwd_hit_r <= 1'b0;
      end
      if (ram_we) begin
        chan_vld_r[s1_idx_r] <= 1'b1;
      end
      if (adv) begin
        regional_r <= upd.reg_new;
        received_r <= received_nxt;
      end
    end
  end

  // Stage payload: capture at accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_op;
      s1_inr_r   <= in_rng;
      s1_idx_r   <= rd_idx;
      s1_sid_r   <= in_service_id;
      s1_amt_r   <= in_credit_amount;
      s1_vld_r   <= in_rng && chan_vld_r[rd_idx];
      fwd_data_r <= upd.ch_new;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_returned_r <= upd.fire;
      out_msg_r      <= upd.fire ? flow_id_r : '0;
      out_word_r     <= upd.fire
                        ? ((cri_pkg::WORD_W'(s1_sid_r) << cri_pkg::SID_SHIFT)
                           | cri_pkg::WORD_W'(upd.give))
                        : '0;
      out_cnt_r      <= upd.give;
      out_reg_r      <= upd.reg_new;
      out_rcv_r      <= received_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_returned        = out_returned_r;
  assign out_message_service = out_msg_r;
  assign out_return_word     = out_word_r;
  assign out_returned_count  = out_cnt_r;
  assign out_regional_level  = out_reg_r;
  assign out_received_total  = out_rcv_r;

  // ------------------------------------------------------------ assertions
  `CRI_ASSERT_NOW(a_ret_nonzero, out_valid_r && out_returned_r, out_cnt_r != '0)
  `CRI_ASSERT_NOW(a_noret_empty, out_valid_r && !out_returned_r, (out_word_r == '0) && (out_msg_r == '0))
  `CRI_ASSERT_NOW(a_fwd_live, fwd_hit_r, s1_v_r)
  `CRI_ASSERT_NOW(a_ready_free, !out_valid_r, in_ready)
  `CRI_ASSERT_NEXT(a_adv_shows, adv, out_valid_r)

endmodule

FILE: sv/cri_ram.sv
// ----------------------------------------------------------------------------
// Credit return ingress generic RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cri_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/cri_thresh.sv
// ----------------------------------------------------------------------------
// Credit return ingress threshold
// Registered return threshold derived from the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cri_thresh (
  input  logic                     clk,
  input  logic [cri_pkg::CC_W-1:0] channel_count,
  input  logic [cri_pkg::MB_W-1:0] min_buffer,
  output logic [cri_pkg::CW-1:0]   thr
);

  logic [cri_pkg::PW-1:0] prod;
  logic [cri_pkg::PW:0]   rest;
  logic [cri_pkg::CW-1:0] thr_nxt;
  logic [cri_pkg::CW-1:0] thr_r;

  always_comb begin
    prod = cri_pkg::PW'(channel_count) * cri_pkg::PW'(min_buffer);
    rest = (cri_pkg::PW + 1)'(cri_pkg::FIFO_SIZE) - {1'b0, prod};
    if ({1'b0, prod} > (cri_pkg::PW + 1)'(cri_pkg::FIFO_SIZE)) begin
      thr_nxt = cri_pkg::HALF_FIFO;
    end else if (rest < (cri_pkg::PW + 1)'(cri_pkg::HALF_FIFO)) begin
      thr_nxt = cri_pkg::CW'(rest);
    end else begin
      thr_nxt = cri_pkg::HALF_FIFO;
    end
  end

  always_ff @(posedge clk) begin
    thr_r <= thr_nxt;
  end

  assign thr = thr_r;

endmodule

FILE: sv/cri_update.sv
// ----------------------------------------------------------------------------
// Credit return ingress update
// Modify step: acquire with saturation, or check and return a channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cri_update (
  input  logic                   op,
  input  logic                   in_range,
  input  logic [cri_pkg::CW-1:0] credits,
  input  logic [cri_pkg::CW-1:0] regional,
  input  logic [cri_pkg::CW-1:0] amount,
  input  logic [cri_pkg::CW-1:0] thr,
  output cri_pkg::upd_t          upd
);

  logic [cri_pkg::CW:0] ch_sum;
  logic [cri_pkg::CW:0] reg_sum;
  logic                 cond;

  always_comb begin
    ch_sum  = {1'b0, credits} + {1'b0, amount};
    reg_sum = {1'b0, regional} + {1'b0, amount};
    cond    = ((credits != '0) && (regional > thr)) || (credits > (thr >> 1));

    upd.fire    = 1'b0;
    upd.ch_wr   = 1'b0;
    upd.ch_new  = credits;
    upd.reg_new = regional;
    upd.give    = '0;

    if (in_range) begin
      case (op)
        cri_pkg::OP_ACQUIRE: begin
          upd.ch_wr   = 1'b1;
          upd.ch_new  = (ch_sum > {1'b0, cri_pkg::CNT_MAX}) ? cri_pkg::CNT_MAX
                                                           : cri_pkg::CW'(ch_sum);
          upd.reg_new = (reg_sum > {1'b0, cri_pkg::CNT_MAX}) ? cri_pkg::CNT_MAX
                                                            : cri_pkg::CW'(reg_sum);
        end
        cri_pkg::OP_CHECK: begin
          if (cond) begin
            upd.fire    = 1'b1;
            upd.ch_wr   = 1'b1;
            upd.ch_new  = '0;
            upd.give    = credits;
            upd.reg_new = (regional > credits) ? (regional - credits) : '0;
          end
        end
        default: begin
          upd.fire = 1'b0;
        end
      endcase
    end
  end

endmodule
